@@ hw/rtl/two_link_inverse_kinematics_macros.svh @@
// ----------------------------------------------------------------------------
// Two-link inverse kinematics assertion macros
// Shared property forms for the checks in two_link_inverse_kinematics.sv.
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_INVERSE_KINEMATICS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLIK_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLIK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/tlik_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-link inverse kinematics package
// Field widths, angle constants, the arctangent table and shared types.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int XW = 18;
	localparam int LW = 16;
	localparam int HW = 19;
	localparam int SHW = 20;
	localparam int ELW = 18;
	localparam int IDXW = 2;
	localparam int NW = 38;
	localparam int DW = 34;
	localparam int CW = 48;
	localparam int ZW = 34;
	localparam int NORM_STEPS = 6;
	localparam int NORM_TOP = 41;

	localparam logic [LW-1:0] L1_RESET = 16'd29491;
	localparam logic [LW-1:0] L2_RESET = 16'd32768;
	localparam logic [HW-1:0] LIFT_RESET = 19'h7FD71;

	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
		32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef enum logic [IDXW-1:0] {
		REG_LINK_ONE = 2'd0,
		REG_LINK_TWO = 2'd1,
		REG_LIFT     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic unreach;
	} ds_flags_t;

	function automatic int cordic_latency(int stages);
		return stages + NORM_STEPS + 3;
	endfunction

endpackage

@@ hw/rtl/two_link_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-link planar inverse kinematics
// Joint angles of a two-link arm for a streamed end-effector target.
// ----------------------------------------------------------------------------
// The block takes one target per clock while the output is taken, and returns
// one set of joint angles per target, in order. The pipeline depth is set by the
// bit-per-stage divider and square root, which take FRAC_BITS + 1 stages each,
// and by the three arctangent units working side by side, each with one stage
// per iteration. When the result at the output is not taken the whole pipeline
// holds. Link lengths and the lift angle are meant to be written only while no
// request is in flight.
module two_link_inverse_kinematics import tlik_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // target_x, target_y
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [63:0] m_axis_tdata,   // shoulder_angle, elbow_angle, height_angle
	output logic m_axis_tuser,          // unreachable
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [IDXW-1:0] cfg_index,
	input  logic [HW-1:0] cfg_data
);
	`include "two_link_inverse_kinematics_macros.svh"

	localparam int AW = FRAC_BITS + 2;
	localparam int GW = FRAC_BITS + 3;
	localparam int SW = FRAC_BITS + 4;
	localparam int CL = cordic_latency(CORDIC_STAGES);

	logic [LW-1:0] l1_q, l2_q;
	logic [HW-1:0] lift_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= L1_RESET;
			l2_q <= L2_RESET;
			lift_q <= LIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINK_ONE: l1_q <= cfg_data[LW-1:0];
				REG_LINK_TWO: l2_q <= cfg_data[LW-1:0];
				REG_LIFT:     lift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [XW-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [2*XW-1:0] xx_s2, yy_s2;
	logic [2*LW-1:0] l11_s2, l22_s2, l12_s2;
	logic signed [NW-1:0] num_s3;
	logic [DW-1:0] den_s3;

	assign en = !v_s6 || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_axis_tdata[XW-1:0];
			y_s1 <= s_axis_tdata[2*XW-1:XW];
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			l11_s2 <= l1_q * l1_q;
			l22_s2 <= l2_q * l2_q;
			l12_s2 <= l1_q * l2_q;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			num_s3 <= NW'(xx_s2) + NW'(yy_s2) - NW'(l11_s2) - NW'(l22_s2);
			den_s3 <= {1'b0, l12_s2, 1'b0};
			x_s3 <= x_s2;
			y_s3 <= y_s2;
		end
	end

	ds_flags_t ds_flags;
	logic signed [AW-1:0] ds_d;
	logic [FRAC_BITS:0] ds_s;
	logic [2*XW-1:0] ds_side;

	tlik_divsqrt #(
		.FRAC_BITS(FRAC_BITS),
		.SIDE_W(2 * XW)
	) u_divsqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s3),
		.num(num_s3),
		.den(den_s3),
		.side_in({y_s3, x_s3}),
		.flags(ds_flags),
		.cos_d(ds_d),
		.sin_s(ds_s),
		.side_out(ds_side)
	);

	logic un_s4, un_s5, un_s6;
	logic signed [AW-1:0] d_s4;
	logic [FRAC_BITS:0] s_s4;
	logic [LW+FRAC_BITS:0] ps_s4;
	logic signed [LW+FRAC_BITS+2:0] pd_s4;
	logic signed [CW-1:0] xa_s5, ya_s5, xb_s5, yb_s5, xc_s5, yc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= ds_flags.valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s4 <= l2_q * ds_s;
			pd_s4 <= $signed({1'b0, l2_q}) * ds_d;
			d_s4 <= ds_d;
			s_s4 <= ds_s;
			x_s4 <= ds_side[XW-1:0];
			y_s4 <= ds_side[2*XW-1:XW];
			un_s4 <= ds_flags.unreach;
			xc_s5 <= CW'($signed({1'b0, l1_q, {FRAC_BITS{1'b0}}})) + CW'(pd_s4);
			yc_s5 <= CW'(ps_s4);
			xa_s5 <= CW'(d_s4);
			ya_s5 <= CW'(s_s4);
			xb_s5 <= CW'(x_s4);
			yb_s5 <= CW'(y_s4);
			un_s5 <= un_s4;
		end
	end

	logic signed [GW-1:0] ang_elbow, ang_target, ang_link;

	tlik_cordic #(
		.FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic_elbow (
		.clk(clk),
		.en(en),
		.y_in(ya_s5),
		.x_in(xa_s5),
		.angle(ang_elbow)
	);

	tlik_cordic #(
		.FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic_target (
		.clk(clk),
		.en(en),
		.y_in(yb_s5),
		.x_in(xb_s5),
		.angle(ang_target)
	);

	tlik_cordic #(
		.FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic_link (
		.clk(clk),
		.en(en),
		.y_in(yc_s5),
		.x_in(xc_s5),
		.angle(ang_link)
	);

	logic cv_s [1:CL];
	logic cu_s [1:CL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s <= '{default: 1'b0};
		end else if (en) begin
			cv_s[1] <= v_s5;
			for (int k = 2; k <= CL; k++) begin
				cv_s[k] <= cv_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s[1] <= un_s5;
			for (int k = 2; k <= CL; k++) begin
				cu_s[k] <= cu_s[k-1];
			end
		end
	end

	logic signed [SW-1:0] tsum;
	logic [SHW-1:0] sh_s6;
	logic [ELW-1:0] el_s6;

	assign tsum = SW'(ang_target) + SW'(ang_link);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= cv_s[CL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s6 <= SHW'(-tsum);
			el_s6 <= ELW'(ang_elbow);
			un_s6 <= cu_s[CL];
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata = {7'b0, lift_q, el_s6, sh_s6};
	assign m_axis_tuser = un_s6;

	`TLIK_ASSERT_IMPL(a_unreach_no_sine, ds_flags.valid && ds_flags.unreach, ds_s == '0,
		"clamped cosine term left a nonzero sine")
	`TLIK_ASSERT_IMPL(a_zero_cos_unit_sine, ds_flags.valid && (ds_d == '0),
		ds_s == ((FRAC_BITS + 1)'(1) << FRAC_BITS), "zero cosine term without unit sine")
	`TLIK_ASSERT_NEXT(a_stall_holds_pipe, !s_axis_tready,
		(v_s5 == $past(v_s5)) && (cv_s[CL] == $past(cv_s[CL])),
		"pipeline moved during a stall")

endmodule

@@ hw/rtl/tlik_divsqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine and sine term pipeline
// Restoring division to the clamped cosine term, then a digit-by-digit root.
// ----------------------------------------------------------------------------
module tlik_divsqrt import tlik_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W = 36
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SIDE_W-1:0] side_in,
	output ds_flags_t flags,
	output logic signed [FRAC_BITS+1:0] cos_d,
	output logic [FRAC_BITS:0] sin_s,
	output logic [SIDE_W-1:0] side_out
);
	localparam int QW = FRAC_BITS + 1;
	localparam int RW = DW + 1;
	localparam int AW = FRAC_BITS + 2;
	localparam int N = FRAC_BITS + 1;
	localparam int VW = 2 * N;
	localparam int MW = N + 3;
	localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;
	localparam logic [VW-1:0] ONE_SQ = VW'(1) << (2 * FRAC_BITS);

	logic v_s1, neg_s1;
	logic [NW-1:0] mag_s1;
	logic [DW-1:0] den_s1;
	logic [SIDE_W-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[NW-1];
			mag_s1 <= num[NW-1] ? NW'(-num) : NW'(num);
			den_s1 <= den;
			side_s1 <= side_in;
		end
	end

	logic dv_s [1:QW];
	logic dneg_s [1:QW];
	logic dclamp_s [1:QW];
	logic dzero_s [1:QW];
	logic [RW-1:0] drem_s [1:QW];
	logic [QW-1:0] dq_s [1:QW];
	logic [DW-1:0] dden_s [1:QW];
	logic [SIDE_W-1:0] dside_s [1:QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic vi, negi, clampi, zeroi, ge;
		logic [RW-1:0] trial;
		logic [QW-1:0] qi;
		logic [DW-1:0] deni;
		logic [SIDE_W-1:0] sidei;
		if (j == 0) begin : g_first
			assign vi = v_s1;
			assign negi = neg_s1;
			assign clampi = mag_s1 > NW'(den_s1);
			assign zeroi = (den_s1 == '0);
			assign trial = RW'(mag_s1);
			assign qi = '0;
			assign deni = den_s1;
			assign sidei = side_s1;
		end else begin : g_next
			assign vi = dv_s[j];
			assign negi = dneg_s[j];
			assign clampi = dclamp_s[j];
			assign zeroi = dzero_s[j];
			assign trial = {drem_s[j][RW-2:0], 1'b0};
			assign qi = dq_s[j];
			assign deni = dden_s[j];
			assign sidei = dside_s[j];
		end
		assign ge = (trial >= RW'(deni));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_s[j+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[j+1] <= ge ? trial - RW'(deni) : trial;
				dq_s[j+1] <= {qi[QW-2:0], ge};
				dneg_s[j+1] <= negi;
				dclamp_s[j+1] <= clampi;
				dzero_s[j+1] <= zeroi;
				dden_s[j+1] <= deni;
				dside_s[j+1] <= sidei;
			end
		end
	end

	logic v_s2, un_s2, v_s3, un_s3, v_s4, un_s4;
	logic signed [AW-1:0] d_s2, d_s3, d_s4;
	logic signed [2*AW-1:0] dsq_s3;
	logic [VW-1:0] rad_s4;
	logic [SIDE_W-1:0] side_s2, side_s3, side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= dv_s[QW];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dclamp_s[QW]) begin
				d_s2 <= dneg_s[QW] ? -ONE : ONE;
			end else if (dzero_s[QW]) begin
				d_s2 <= '0;
			end else begin
				d_s2 <= dneg_s[QW] ? -$signed({1'b0, dq_s[QW]}) : $signed({1'b0, dq_s[QW]});
			end
			un_s2 <= dclamp_s[QW];
			side_s2 <= dside_s[QW];
			dsq_s3 <= d_s2 * d_s2;
			d_s3 <= d_s2;
			un_s3 <= un_s2;
			side_s3 <= side_s2;
			rad_s4 <= ONE_SQ - VW'(dsq_s3);
			d_s4 <= d_s3;
			un_s4 <= un_s3;
			side_s4 <= side_s3;
		end
	end

	logic sv_s [1:N];
	logic sun_s [1:N];
	logic [MW-1:0] srem_s [1:N];
	logic [N-1:0] sroot_s [1:N];
	logic [VW-1:0] srad_s [1:N];
	logic signed [AW-1:0] sd_s [1:N];
	logic [SIDE_W-1:0] sside_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_root
		localparam int I = N - 1 - k;
		logic vi, uni, ge;
		logic [MW-1:0] remi, rs, trial;
		logic [N-1:0] rooti;
		logic [VW-1:0] radi;
		logic signed [AW-1:0] di;
		logic [SIDE_W-1:0] sidei;
		if (k == 0) begin : g_first
			assign vi = v_s4;
			assign uni = un_s4;
			assign remi = '0;
			assign rooti = '0;
			assign radi = rad_s4;
			assign di = d_s4;
			assign sidei = side_s4;
		end else begin : g_next
			assign vi = sv_s[k];
			assign uni = sun_s[k];
			assign remi = srem_s[k];
			assign rooti = sroot_s[k];
			assign radi = srad_s[k];
			assign di = sd_s[k];
			assign sidei = sside_s[k];
		end
		assign rs = {remi[MW-3:0], radi[2*I+1 -: 2]};
		assign trial = MW'({rooti, 2'b01});
		assign ge = (rs >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k+1] <= 1'b0;
			end else if (en) begin
				sv_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[k+1] <= ge ? rs - trial : rs;
				sroot_s[k+1] <= {rooti[N-2:0], ge};
				srad_s[k+1] <= radi;
				sd_s[k+1] <= di;
				sun_s[k+1] <= uni;
				sside_s[k+1] <= sidei;
			end
		end
	end

	assign flags.valid = sv_s[N];
	assign flags.unreach = sun_s[N];
	assign cos_d = sd_s[N];
	assign sin_s = sroot_s[N];
	assign side_out = sside_s[N];

endmodule

@@ hw/rtl/tlik_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined arctangent unit
// Quadrant fold, normalising shift, vectoring iterations, clamp and rounding.
// ----------------------------------------------------------------------------
module tlik_cordic import tlik_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	output logic signed [FRAC_BITS+2:0] angle
);
	localparam int AW = FRAC_BITS + 3;
	localparam int RS = 30 - FRAC_BITS;

	logic signed [CW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (x_in == '0) && (y_in == '0);
			if (x_in[CW-1] && !y_in[CW-1]) begin
				x_s1 <= y_in;
				y_s1 <= -x_in;
				z_s1 <= HALF_PI_Q30;
			end else if (x_in[CW-1]) begin
				x_s1 <= -y_in;
				y_s1 <= x_in;
				z_s1 <= -HALF_PI_Q30;
			end else begin
				x_s1 <= x_in;
				y_s1 <= y_in;
				z_s1 <= '0;
			end
		end
	end

	logic signed [CW-1:0] nx_s [1:NORM_STEPS];
	logic signed [CW-1:0] ny_s [1:NORM_STEPS];
	logic signed [ZW-1:0] nz_s [1:NORM_STEPS];
	logic nzero_s [1:NORM_STEPS];

	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int SH = 1 << (NORM_STEPS - 1 - j);
		localparam logic signed [CW-1:0] LIM = CW'(64'd1 << (NORM_TOP - SH));
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;
		logic zeroi, fits;
		if (j == 0) begin : g_first
			assign xi = x_s1;
			assign yi = y_s1;
			assign zi = z_s1;
			assign zeroi = zero_s1;
		end else begin : g_next
			assign xi = nx_s[j];
			assign yi = ny_s[j];
			assign zi = nz_s[j];
			assign zeroi = nzero_s[j];
		end
		assign fits = (xi < LIM) && (xi > -LIM) && (yi < LIM) && (yi > -LIM);

		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[j+1] <= fits ? xi <<< SH : xi;
				ny_s[j+1] <= fits ? yi <<< SH : yi;
				nz_s[j+1] <= zi;
				nzero_s[j+1] <= zeroi;
			end
		end
	end

	logic signed [CW-1:0] cx_s [1:CORDIC_STAGES];
	logic signed [CW-1:0] cy_s [1:CORDIC_STAGES];
	logic signed [ZW-1:0] cz_s [1:CORDIC_STAGES];
	logic czero_s [1:CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi;
		logic zeroi;
		if (i == 0) begin : g_first
			assign xi = nx_s[NORM_STEPS];
			assign yi = ny_s[NORM_STEPS];
			assign zi = nz_s[NORM_STEPS];
			assign zeroi = nzero_s[NORM_STEPS];
		end else begin : g_next
			assign xi = cx_s[i];
			assign yi = cy_s[i];
			assign zi = cz_s[i];
			assign zeroi = czero_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[CW-1] && (yi != '0)) begin
					cx_s[i+1] <= xi + (yi >>> i);
					cy_s[i+1] <= yi - (xi >>> i);
					cz_s[i+1] <= zi + ANG;
				end else begin
					cx_s[i+1] <= xi - (yi >>> i);
					cy_s[i+1] <= yi + (xi >>> i);
					cz_s[i+1] <= zi - ANG;
				end
				czero_s[i+1] <= zeroi;
			end
		end
	end

	logic signed [ZW-1:0] zc_s, zlast;
	logic [ZW-1:0] zmag, zrnd;

	assign zlast = cz_s[CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			if (czero_s[CORDIC_STAGES]) begin
				zc_s <= '0;
			end else if (zlast > PI_Q30) begin
				zc_s <= PI_Q30;
			end else if (zlast < -PI_Q30) begin
				zc_s <= -PI_Q30;
			end else begin
				zc_s <= zlast;
			end
		end
	end

	assign zmag = zc_s[ZW-1] ? ZW'(-zc_s) : ZW'(zc_s);
	assign zrnd = (zmag + (ZW'(1) << (RS - 1))) >> RS;

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= zc_s[ZW-1] ? -$signed(AW'(zrnd)) : $signed(AW'(zrnd));
		end
	end

endmodule
